// ----- rtl/rszc_pkg.sv -----
// rszc_pkg: shared types and constants for range_smooth_zone_classifier
// no dependencies
`timescale 1ns / 1ps
package rszc_pkg;

  localparam logic [1:0] ZONE_NEAR    = 2'd0;
  localparam logic [1:0] ZONE_CAUTION = 2'd1;
  localparam logic [1:0] ZONE_CLEAR   = 2'd2;
  localparam logic [1:0] ZONE_UNKNOWN = 2'd3;

  localparam logic [1:0] REG_NEAR    = 2'd0;
  localparam logic [1:0] REG_CAUTION = 2'd1;
  localparam logic [1:0] REG_HYST    = 2'd2;
  localparam logic [1:0] REG_ACTIVE  = 2'd3;

  // divider request and reply
  typedef struct packed {
    logic        start;
    logic [39:0] dividend;
    logic [32:0] divisor;
  } div_req_t;

  typedef struct packed {
    logic        done;
    logic [39:0] quotient;
  } div_rsp_t;

endpackage

// ----- rtl/range_smooth_zone_classifier.sv -----
// range_smooth_zone_classifier: per-channel moving average, hysteresis zone and statistics
// path: a rejected or invalid beat goes from the check straight to output; a valid beat walks
// the window sum over fill_level entries, fill_level taken after the push, then two serial divisions
// throughput: one item at a time, in_tready rises as the result beat is raised
// reset: synchronous active-low rst_n loads the config defaults, returns to idle and clears ovalid,
// seq and per-channel state, not the window; depends on rszc_pkg and rszc_divider
`timescale 1ns / 1ps
module range_smooth_zone_classifier #(
  parameter int WINDOW   = 8,
  parameter int CHANNELS = 8
) (
  input  logic         clk,
  input  logic         rst_n,
  input  logic         in_tvalid,
  output logic         in_tready,
  input  logic [23:0]  in_tdata,   // channel[2:0], valid_req[3], distance_mm[19:4]
  output logic         out_tvalid,
  input  logic         out_tready,
  output logic [191:0] out_tdata,  // out_channel, rejected, out_valid, result_mm, zone,
                                   // min_mm, max_mm, mean_q8, good_count, bad_count,
                                   // measure_number, zero fill
  input  logic         cfg_valid,
  output logic         cfg_ready,
  input  logic [1:0]   cfg_index,
  input  logic [15:0]  cfg_data
);

  localparam int WB = (WINDOW > 1) ? $clog2(WINDOW) : 1;
  localparam int FB = $clog2(WINDOW + 1);
  localparam int CB = (CHANNELS > 1) ? $clog2(CHANNELS) : 1;
  localparam int DEPTH = CHANNELS * WINDOW;
  localparam int AB = (DEPTH > 1) ? $clog2(DEPTH) : 1;

  typedef enum logic [8:0] {
    S_IDLE  = 9'b000000001,
    S_CHECK = 9'b000000010,
    S_WRITE = 9'b000000100,
    S_SUM   = 9'b000001000,
    S_SUMW  = 9'b000010000,
    S_DIV1  = 9'b000100000,
    S_ZONE  = 9'b001000000,
    S_DIV2  = 9'b010000000,
    S_OUT   = 9'b100000000
  } state_t;

  state_t state_r, state_nxt;

  logic [15:0] near_r, caution_r, hyst_r;
  logic [3:0]  active_r;

  logic [15:0] win_mem [DEPTH];
  logic [15:0] rd_r;

  logic [WB-1:0] slot_r  [CHANNELS];
  logic [FB-1:0] fill_r  [CHANNELS];
  logic [1:0]    zone_r  [CHANNELS];
  logic [15:0]   min_r   [CHANNELS];
  logic [15:0]   max_r   [CHANNELS];
  logic [23:0]   mean_r  [CHANNELS];
  logic [31:0]   good_r  [CHANNELS];
  logic [31:0]   bad_r   [CHANNELS];
  logic [31:0]   seq_r;

  logic [2:0]    ch_r;
  logic          vld_r;
  logic [15:0]   raw_r;
  logic [CB-1:0] ci;
  logic [FB-1:0] idx_r;
  logic [FB-1:0] n_r;
  logic [21:0]   sum_r;
  logic [15:0]   res_r;
  logic [31:0]   cnt_r;
  logic          neg_r;
  logic          rej_r;
  logic [31:0]   num_r;
  logic [191:0]  odata_r;
  logic          ovalid_r;

  rszc_pkg::div_req_t dreq;
  rszc_pkg::div_rsp_t drsp;

  rszc_divider u_div (.clk(clk), .rst_n(rst_n), .req(dreq), .rsp(drsp));

  assign ci = CB'(ch_r);
  assign in_tready = state_r == S_IDLE;
  assign cfg_ready = 1'b1;
  assign out_tvalid = ovalid_r;
  assign out_tdata = odata_r;

  logic [AB-1:0] wr_addr, rd_addr;
  assign wr_addr = AB'(ci * WINDOW) + AB'(slot_r[ci]);
  assign rd_addr = AB'(ci * WINDOW) + AB'(idx_r);

  always_ff @(posedge clk) begin
    if (state_r == S_WRITE) win_mem[wr_addr] <= raw_r;
    rd_r <= win_mem[rd_addr];
  end

  // zone decision
  logic signed [17:0] d_s, nr_s, ct_s, hy_s;
  logic [1:0] zone_new;
  always_comb begin
    d_s  = {2'b0, res_r};
    nr_s = {2'b0, near_r};
    ct_s = {2'b0, caution_r};
    hy_s = {2'b0, hyst_r};
    case (zone_r[ci])
      rszc_pkg::ZONE_NEAR:
        zone_new = (d_s > nr_s + hy_s) ? rszc_pkg::ZONE_CAUTION : rszc_pkg::ZONE_NEAR;
      rszc_pkg::ZONE_CAUTION: begin
        if (d_s < nr_s - hy_s)      zone_new = rszc_pkg::ZONE_NEAR;
        else if (d_s > ct_s + hy_s) zone_new = rszc_pkg::ZONE_CLEAR;
        else                        zone_new = rszc_pkg::ZONE_CAUTION;
      end
      rszc_pkg::ZONE_CLEAR:
        zone_new = (d_s < ct_s - hy_s) ? rszc_pkg::ZONE_CAUTION : rszc_pkg::ZONE_CLEAR;
      default: begin
        if (res_r <= near_r)         zone_new = rszc_pkg::ZONE_NEAR;
        else if (res_r <= caution_r) zone_new = rszc_pkg::ZONE_CAUTION;
        else                         zone_new = rszc_pkg::ZONE_CLEAR;
      end
    endcase
  end

  logic [24:0] delta;
  logic [23:0] mag;
  assign delta = {1'b0, res_r, 8'd0} - {1'b0, mean_r[ci]};
  assign mag = delta[24] ? 24'(-delta) : delta[23:0];

  always_comb begin
    state_nxt = state_r;
    dreq = '0;
    case (state_r)
      S_IDLE:  if (in_tvalid) state_nxt = S_CHECK;
      S_CHECK: begin
        if ({1'b0, ch_r} >= active_r || 32'(ch_r) >= CHANNELS) state_nxt = S_OUT;
        else if (vld_r) state_nxt = S_WRITE;
        else state_nxt = S_OUT;
      end
      S_WRITE: state_nxt = S_SUM;
      S_SUM:   state_nxt = S_SUMW;
      S_SUMW: begin
        if (idx_r == n_r) begin
          state_nxt = S_DIV1;
          dreq.start = 1'b1;
          dreq.dividend = 40'(sum_r + 22'(rd_r));
          dreq.divisor = 33'(n_r);
        end
      end
      S_DIV1: if (drsp.done) state_nxt = S_ZONE;
      S_ZONE: begin
        state_nxt = S_DIV2;
        dreq.start = 1'b1;
        dreq.dividend = 40'(mag);
        dreq.divisor = (cnt_r == 32'd0) ? 33'h100000000 : {1'b0, cnt_r};
      end
      S_DIV2: if (drsp.done) state_nxt = S_OUT;
      S_OUT:  if (!ovalid_r) state_nxt = S_IDLE;
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r  <= S_IDLE;
      near_r   <= 16'd300;
      caution_r <= 16'd1000;
      hyst_r   <= 16'd50;
      active_r <= 4'd8;
      seq_r    <= '0;
      ovalid_r <= 1'b0;
      for (int i = 0; i < CHANNELS; i++) begin
        slot_r[i] <= '0;
        fill_r[i] <= '0;
        zone_r[i] <= rszc_pkg::ZONE_UNKNOWN;
        min_r[i]  <= '0;
        max_r[i]  <= '0;
        mean_r[i] <= '0;
        good_r[i] <= '0;
        bad_r[i]  <= '0;
      end
    end else begin
      state_r <= state_nxt;
      if (cfg_valid) begin
        case (cfg_index)
          rszc_pkg::REG_NEAR:    near_r    <= cfg_data;
          rszc_pkg::REG_CAUTION: caution_r <= cfg_data;
          rszc_pkg::REG_HYST:    hyst_r    <= cfg_data;
          rszc_pkg::REG_ACTIVE:  active_r  <= cfg_data[3:0];
          default: ;
        endcase
      end
      if (ovalid_r && out_tready) ovalid_r <= 1'b0;
      case (state_r)
        S_IDLE: if (in_tvalid) begin
          ch_r  <= in_tdata[2:0];
          vld_r <= in_tdata[3];
          raw_r <= in_tdata[19:4];
        end
        S_CHECK: begin
          rej_r <= ({1'b0, ch_r} >= active_r) || (32'(ch_r) >= CHANNELS);
          num_r <= seq_r;
          res_r <= raw_r;
          if (!(({1'b0, ch_r} >= active_r) || (32'(ch_r) >= CHANNELS))) begin
            seq_r <= seq_r + 32'd1;
            if (!vld_r) bad_r[ci] <= bad_r[ci] + 32'd1;
          end
        end
        S_WRITE: begin
          slot_r[ci] <= (32'(slot_r[ci]) == WINDOW - 1) ? '0 : slot_r[ci] + WB'(1);
          if (32'(fill_r[ci]) < WINDOW) begin
            fill_r[ci] <= fill_r[ci] + FB'(1);
            n_r <= fill_r[ci] + FB'(1);
          end else begin
            n_r <= fill_r[ci];
          end
          idx_r <= '0;
          sum_r <= '0;
        end
        S_SUM: idx_r <= idx_r + FB'(1);
        S_SUMW: if (idx_r != n_r) begin
          sum_r <= sum_r + 22'(rd_r);
          idx_r <= idx_r + FB'(1);
        end else begin
          sum_r <= sum_r + 22'(rd_r);
        end
        S_DIV1: if (drsp.done) begin
          res_r <= drsp.quotient[15:0];
          cnt_r <= good_r[ci] + 32'd1;
        end
        S_ZONE: begin
          zone_r[ci] <= zone_new;
          good_r[ci] <= cnt_r;
          if (res_r < min_r[ci] || cnt_r == 32'd1) min_r[ci] <= res_r;
          if (res_r > max_r[ci]) max_r[ci] <= res_r;
          neg_r <= delta[24];
        end
        S_DIV2: if (drsp.done) begin
          mean_r[ci] <= neg_r ? mean_r[ci] - drsp.quotient[23:0]
                              : mean_r[ci] + drsp.quotient[23:0];
        end
        S_OUT: if (!ovalid_r) begin
          ovalid_r <= 1'b1;
          if (rej_r) odata_r <= {188'd0, 1'b1, ch_r};
          else odata_r <= {17'd0, num_r, bad_r[ci], good_r[ci], mean_r[ci], max_r[ci],
                           min_r[ci], zone_r[ci], res_r, vld_r, 1'b0, ch_r};
        end
        default: ;
      endcase
    end
  end

endmodule

// ----- rtl/rszc_divider.sv -----
// rszc_divider: restoring serial divider, one quotient bit per cycle
// depends on rszc_pkg
`timescale 1ns / 1ps
module rszc_divider (
  input  logic              clk,
  input  logic              rst_n,
  input  rszc_pkg::div_req_t req,
  output rszc_pkg::div_rsp_t rsp
);

  logic [39:0] quo_r, quo_nxt;
  logic [32:0] den_r, den_nxt;
  logic [33:0] rem_r, rem_nxt;
  logic [5:0]  cnt_r, cnt_nxt;
  logic        busy_r, busy_nxt;
  logic        done_r, done_nxt;
  logic [33:0] shifted;

  always_comb begin
    quo_nxt  = quo_r;
    den_nxt  = den_r;
    rem_nxt  = rem_r;
    cnt_nxt  = cnt_r;
    busy_nxt = busy_r;
    done_nxt = 1'b0;
    shifted  = {rem_r[32:0], quo_r[39]};
    if (req.start) begin
      quo_nxt  = req.dividend;
      den_nxt  = req.divisor;
      rem_nxt  = '0;
      cnt_nxt  = 6'd40;
      busy_nxt = 1'b1;
    end else if (busy_r) begin
      if (shifted >= {1'b0, den_r}) begin
        rem_nxt = shifted - {1'b0, den_r};
        quo_nxt = {quo_r[38:0], 1'b1};
      end else begin
        rem_nxt = shifted;
        quo_nxt = {quo_r[38:0], 1'b0};
      end
      cnt_nxt = cnt_r - 6'd1;
      if (cnt_r == 6'd1) begin
        busy_nxt = 1'b0;
        done_nxt = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    quo_r <= quo_nxt;
    den_r <= den_nxt;
    rem_r <= rem_nxt;
    if (!rst_n) begin
      cnt_r  <= '0;
      busy_r <= 1'b0;
      done_r <= 1'b0;
    end else begin
      cnt_r  <= cnt_nxt;
      busy_r <= busy_nxt;
      done_r <= done_nxt;
    end
  end

  assign rsp.done     = done_r;
  assign rsp.quotient = quo_r;

endmodule

// ----- verif/tb_range_smooth_zone_classifier.sv -----
// tb_range_smooth_zone_classifier: self-checking testbench for the range classifier
// predicts each result beat from its own per-channel window, zone and statistics state
// depends on rszc_pkg and the range_smooth_zone_classifier rtl
`timescale 1ns / 1ps
module tb_range_smooth_zone_classifier;

  localparam int WIN   = 8;
  localparam int NCH   = 8;
  localparam int LIMIT = 20000;

  logic         clk;
  logic         rst_n;
  logic         in_tvalid;
  logic         in_tready;
  logic [23:0]  in_tdata;
  logic         out_tvalid;
  logic         out_tready;
  logic [191:0] out_tdata;
  logic         cfg_valid;
  logic         cfg_ready;
  logic [1:0]   cfg_index;
  logic [15:0]  cfg_data;

  range_smooth_zone_classifier #(.WINDOW(WIN), .CHANNELS(NCH)) u_top (
    .clk(clk), .rst_n(rst_n),
    .in_tvalid(in_tvalid), .in_tready(in_tready), .in_tdata(in_tdata),
    .out_tvalid(out_tvalid), .out_tready(out_tready), .out_tdata(out_tdata),
    .cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .cfg_index(cfg_index),
    .cfg_data(cfg_data)
  );

  // predictor state
  logic [15:0] win_mem [NCH][WIN];
  logic [2:0]  slot_ptr [NCH];
  logic [3:0]  fill_cnt [NCH];
  logic [1:0]  zone_st [NCH];
  logic [15:0] min_st [NCH];
  logic [15:0] max_st [NCH];
  logic [23:0] mean_st [NCH];
  logic [31:0] good_st [NCH];
  logic [31:0] bad_st [NCH];
  logic [31:0] seq_num;
  logic [15:0] near_thr, caution_thr, hyst_thr;
  logic [3:0]  active_num;

  logic [23:0]  item_q [$];
  logic [191:0] result_q [$];
  int send_idle, recv_idle, errs, quiet;
  bit hold;

  localparam int NF = 11;
  int    f_lo [NF] = '{0, 3, 4, 5, 21, 23, 39, 55, 79, 111, 143};
  int    f_w  [NF] = '{3, 1, 1, 16, 2, 16, 16, 24, 32, 32, 32};
  string f_nm [NF] = '{"out_channel", "rejected", "out_valid", "result_mm", "zone",
                       "min_mm", "max_mm", "mean_q8", "good_count", "bad_count",
                       "measure_number"};

  function automatic logic [1:0] next_zone(logic [1:0] cur, longint d);
    longint nr, ct, hy;
    nr = near_thr;
    ct = caution_thr;
    hy = hyst_thr;
    case (cur)
      rszc_pkg::ZONE_NEAR:
        next_zone = (d > nr + hy) ? rszc_pkg::ZONE_CAUTION : rszc_pkg::ZONE_NEAR;
      rszc_pkg::ZONE_CAUTION: begin
        if (d < nr - hy) next_zone = rszc_pkg::ZONE_NEAR;
        else if (d > ct + hy) next_zone = rszc_pkg::ZONE_CLEAR;
        else next_zone = rszc_pkg::ZONE_CAUTION;
      end
      rszc_pkg::ZONE_CLEAR:
        next_zone = (d < ct - hy) ? rszc_pkg::ZONE_CAUTION : rszc_pkg::ZONE_CLEAR;
      default: begin
        if (d <= nr) next_zone = rszc_pkg::ZONE_NEAR;
        else if (d <= ct) next_zone = rszc_pkg::ZONE_CAUTION;
        else next_zone = rszc_pkg::ZONE_CLEAR;
      end
    endcase
  endfunction

  task automatic predict_range(input logic [23:0] beat);
    logic [191:0] r;
    logic [2:0]   ch;
    logic [15:0]  d, sm;
    logic [31:0]  sum;
    longint       delta, dv;
    ch = beat[2:0];
    d = beat[19:4];
    r = '0;
    r[2:0] = ch;
    if (ch >= active_num) begin
      r[3] = 1'b1;
      result_q.push_back(r);
      return;
    end
    r[174:143] = seq_num;
    seq_num++;
    if (beat[3]) begin
      win_mem[ch][slot_ptr[ch]] = d;
      slot_ptr[ch] = slot_ptr[ch] + 3'd1;
      if (fill_cnt[ch] < WIN) fill_cnt[ch]++;
      sum = 0;
      for (int i = 0; i < fill_cnt[ch]; i++) sum += win_mem[ch][i];
      sm = 16'(sum / fill_cnt[ch]);
      zone_st[ch] = next_zone(zone_st[ch], longint'(sm));
      good_st[ch]++;
      if (sm < min_st[ch] || good_st[ch] == 1) min_st[ch] = sm;
      if (sm > max_st[ch]) max_st[ch] = sm;
      dv = (good_st[ch] == 0) ? 64'sd4294967296 : longint'(good_st[ch]);
      delta = longint'(sm) * 256 - longint'(mean_st[ch]);
      mean_st[ch] = 24'(longint'(mean_st[ch]) + delta / dv);
    end else begin
      sm = d;
      bad_st[ch]++;
    end
    r[4] = beat[3];
    r[20:5] = sm;
    r[22:21] = zone_st[ch];
    r[38:23] = min_st[ch];
    r[54:39] = max_st[ch];
    r[78:55] = mean_st[ch];
    r[110:79] = good_st[ch];
    r[142:111] = bad_st[ch];
    result_q.push_back(r);
  endtask

  function automatic logic [23:0] range_beat(int ch, bit v, int d);
    range_beat = {4'd0, 16'(d), v, 3'(ch)};
  endfunction

  // distances cluster around the thresholds so the hysteresis edges get exercised
  function automatic logic [23:0] random_beat();
    int d, sel;
    sel = $urandom_range(9);
    if (sel < 3) d = int'(near_thr) + $urandom_range(300) - 150;
    else if (sel < 6) d = int'(caution_thr) + $urandom_range(300) - 150;
    else if (sel < 8) d = $urandom_range(2000);
    else d = $urandom_range(65535);
    if (d < 0) d = 0;
    if (d > 65535) d = 65535;
    random_beat = range_beat($urandom_range(7), $urandom_range(9) < 8, d);
  endfunction

  initial begin
    clk = 1'b0;
    forever #2 clk = ~clk;
  end

  // input driver
  always @(posedge clk) begin
    if (!rst_n) begin
      in_tvalid <= 1'b0;
      in_tdata <= '0;
    end else begin
      if (in_tvalid && in_tready) predict_range(in_tdata);
      if (!in_tvalid || in_tready) begin
        if (item_q.size() > 0 && !hold && $urandom_range(99) >= send_idle) begin
          in_tdata <= item_q.pop_front();
          in_tvalid <= 1'b1;
        end else begin
          in_tvalid <= 1'b0;
        end
      end
    end
  end

  // result monitor and watchdog
  always @(posedge clk) begin
    logic [191:0] want;
    if (!rst_n) begin
      out_tready <= 1'b0;
      quiet <= 0;
    end else begin
      out_tready <= ($urandom_range(99) >= recv_idle);
      if ((in_tvalid && in_tready) || (out_tvalid && out_tready) || (cfg_valid && cfg_ready))
        quiet <= 0;
      else
        quiet <= quiet + 1;
      if (out_tvalid && out_tready) begin
        if (result_q.size() == 0) begin
          errs++;
          if (errs <= 10) $display("unexpected result beat %h", out_tdata);
        end else begin
          want = result_q.pop_front();
          for (int k = 0; k < NF; k++) begin
            if (((want >> f_lo[k]) & ((192'd1 << f_w[k]) - 1)) !=
                ((out_tdata >> f_lo[k]) & ((192'd1 << f_w[k]) - 1))) begin
              errs++;
              if (errs <= 10)
                $display("%s mismatch: expected %0d actual %0d", f_nm[k],
                         (want >> f_lo[k]) & ((192'd1 << f_w[k]) - 1),
                         (out_tdata >> f_lo[k]) & ((192'd1 << f_w[k]) - 1));
            end
          end
        end
      end
      if (quiet >= LIMIT) begin
        $display("CHECK FAILED");
        $finish;
      end
    end
  end

  task automatic write_reg(input logic [1:0] idx, input logic [15:0] val);
    @(posedge clk);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data <= val;
    do @(posedge clk); while (!cfg_ready);
    cfg_valid <= 1'b0;
    case (idx)
      rszc_pkg::REG_NEAR:    near_thr = val;
      rszc_pkg::REG_CAUTION: caution_thr = val;
      rszc_pkg::REG_HYST:    hyst_thr = val;
      default:               active_num = val[3:0];
    endcase
  endtask

  task automatic drain();
    do @(negedge clk); while (item_q.size() > 0 || in_tvalid || result_q.size() > 0);
  endtask

  initial begin
    rst_n = 1'b0;
    cfg_valid = 1'b0;
    cfg_index = rszc_pkg::REG_NEAR;
    cfg_data = '0;
    errs = 0;
    hold = 1'b0;
    send_idle = 7;
    recv_idle = 84;
    seq_num = 0;
    near_thr = 16'd300;
    caution_thr = 16'd1000;
    hyst_thr = 16'd50;
    active_num = 4'd8;
    for (int c = 0; c < NCH; c++) begin
      slot_ptr[c] = 0;
      fill_cnt[c] = 0;
      zone_st[c] = rszc_pkg::ZONE_UNKNOWN;
      min_st[c] = 0;
      max_st[c] = 0;
      mean_st[c] = 0;
      good_st[c] = 0;
      bad_st[c] = 0;
    end
    repeat (8) @(posedge clk);
    rst_n <= 1'b1;

    // directed: field extremes, first decisions, hysteresis moves on channel 1
    item_q.push_back(range_beat(0, 1, 0));
    item_q.push_back(range_beat(7, 1, 65535));
    item_q.push_back(range_beat(2, 0, 65535));
    item_q.push_back(range_beat(2, 0, 0));
    item_q.push_back(range_beat(3, 1, 300));
    item_q.push_back(range_beat(4, 1, 301));
    item_q.push_back(range_beat(5, 1, 1000));
    item_q.push_back(range_beat(6, 1, 1001));
    item_q.push_back(range_beat(1, 1, 600));
    for (int i = 0; i < 6; i++) item_q.push_back(range_beat(1, 1, 100));
    for (int i = 0; i < 8; i++) item_q.push_back(range_beat(1, 1, 1200 + i * 200));
    item_q.push_back(range_beat(0, 1, 65535));
    drain();

    for (int ph = 0; ph < 3; ph++) begin
      case (ph)
        0: begin
          write_reg(rszc_pkg::REG_NEAR, 16'd0);
          write_reg(rszc_pkg::REG_CAUTION, 16'd0);
          write_reg(rszc_pkg::REG_HYST, 16'hFFFF);
          write_reg(rszc_pkg::REG_ACTIVE, 16'd1);
        end
        1: begin
          send_idle = 84;
          recv_idle = 7;
          write_reg(rszc_pkg::REG_NEAR, 16'hFFFF);
          write_reg(rszc_pkg::REG_CAUTION, 16'hFFFF);
          write_reg(rszc_pkg::REG_HYST, 16'd0);
          write_reg(rszc_pkg::REG_ACTIVE, 16'd5);
        end
        default: begin
          send_idle = 0;
          recv_idle = 0;
          write_reg(rszc_pkg::REG_NEAR, 16'd400);
          write_reg(rszc_pkg::REG_CAUTION, 16'd1200);
          write_reg(rszc_pkg::REG_HYST, 16'd30);
          write_reg(rszc_pkg::REG_ACTIVE, 16'd8);
        end
      endcase
      for (int i = 0; i < 620; i++) item_q.push_back(random_beat());
      if (ph == 1) begin
        repeat (300) @(negedge clk);
        hold = 1'b1;
        do @(negedge clk); while (in_tvalid || result_q.size() > 0);
        hold = 1'b0;
      end
      drain();
    end

    repeat (200) @(negedge clk);
    if (errs == 0 && result_q.size() == 0) begin
      $display("CHECK OK");
    end else begin
      $display("CHECK FAILED");
    end
    $finish;
  end

endmodule

// ----- range_smooth_zone_classifier.f -----
rtl/rszc_pkg.sv
rtl/rszc_divider.sv
rtl/range_smooth_zone_classifier.sv
verif/tb_range_smooth_zone_classifier.sv
